FILE: sv/cfd_pkg.sv
// Shared types and constants of the COBS frame decoder.
package cfd_pkg;

    // Default width of the decoded byte counter.
    localparam int CFD_COUNT_WIDTH = 16;

    // Default depth of the request queue between front and back.
    localparam int CFD_QUEUE_DEPTH = 4;

    // Reset value of the output capacity register.
    localparam logic [15:0] CFD_CAPACITY_RESET = 16'hFFFF;

    // Code byte that announces a full block with no zero after it.
    localparam logic [7:0] CFD_FULL_CODE = 8'hFF;

    // Delimiter byte.
    localparam logic [7:0] CFD_DELIM = 8'h00;

    // Result kinds.
    localparam logic CFD_KIND_DATA = 1'b0;
    localparam logic CFD_KIND_REC  = 1'b1;

    // End record status codes.
    localparam logic [2:0] CFD_ST_OK         = 3'd0;
    localparam logic [2:0] CFD_ST_SHORT      = 3'd1;
    localparam logic [2:0] CFD_ST_UNEXPECTED = 3'd2;
    localparam logic [2:0] CFD_ST_OVERFLOW   = 3'd3;
    localparam logic [2:0] CFD_ST_MISSING    = 3'd4;

    // One classified input byte: an optional data result and an optional record.
    typedef struct packed {
        logic        has_data;
        logic        has_rec;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [15:0] count;
    } cfd_req_t;

endpackage

FILE: sv/cfd_front.sv
// Front end: accepts encoded bytes, tracks the COBS block state and issues requests.
module cfd_front
    import cfd_pkg::*;
#(
    parameter int COUNT_WIDTH = CFD_COUNT_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    input  logic [15:0] capacity,
    input  logic        q_full,
    output logic        q_push,
    output cfd_req_t    q_req
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [7:0]             left_reg, left_next;
    logic                   prev_full_reg, prev_full_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   start_reg, start_next;
    logic                   finished_reg, finished_next;
    logic                   accept;
    logic                   has_data, has_rec;
    logic [7:0]             data_byte;
    logic [2:0]             status;
    logic [31:0]            count_ext, cap_ext, count_next_ext;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign count_ext = 32'(count_reg);
    assign cap_ext   = 32'(capacity);

    // Classify the byte against the current block state.
    always_comb begin
        has_data       = 1'b0;
        has_rec        = 1'b0;
        data_byte      = CFD_DELIM;
        status         = CFD_ST_OK;
        left_next      = left_reg;
        prev_full_next = prev_full_reg;
        count_next     = count_reg;
        finished_next  = finished_reg;
        if (start_reg && s_in_last) begin
            has_rec       = 1'b1;
            status        = CFD_ST_SHORT;
            finished_next = 1'b1;
        end else if (!finished_reg) begin
            if (s_in_byte == CFD_DELIM) begin
                has_rec       = 1'b1;
                status        = (left_reg != 8'd0) ? CFD_ST_UNEXPECTED : CFD_ST_OK;
                finished_next = 1'b1;
            end else if (count_ext >= cap_ext || (&count_reg)) begin
                has_rec       = 1'b1;
                status        = CFD_ST_OVERFLOW;
                finished_next = 1'b1;
            end else if (left_reg != 8'd0) begin
                has_data   = 1'b1;
                data_byte  = s_in_byte;
                count_next = count_reg + CNT_ONE;
                left_next  = left_reg - 8'd1;
            end else begin
                // A new code byte; a zero goes out first unless the last block was full.
                if (!prev_full_reg) begin
                    has_data   = 1'b1;
                    count_next = count_reg + CNT_ONE;
                end
                prev_full_next = (s_in_byte == CFD_FULL_CODE);
                left_next      = s_in_byte - 8'd1;
            end
            if (s_in_last && !finished_next) begin
                has_rec       = 1'b1;
                status        = CFD_ST_MISSING;
                finished_next = 1'b1;
            end
        end
        start_next = 1'b0;
        // The last byte of a buffer returns all buffer state to reset.
        if (s_in_last) begin
            left_next      = 8'd0;
            prev_full_next = 1'b1;
            count_next     = '0;
            start_next     = 1'b1;
            finished_next  = 1'b0;
        end
    end

    // Request toward the queue; the count is the decoded count after this byte.
    always_comb begin
        count_next_ext  = 32'(count_reg);
        if (has_data) begin
            count_next_ext = 32'(count_reg + CNT_ONE);
        end
        q_req.has_data  = has_data;
        q_req.has_rec   = has_rec;
        q_req.data_byte = data_byte;
        q_req.status    = status;
        q_req.count     = count_next_ext[15:0];
        q_push          = accept && (has_data || has_rec);
    end

    // Block state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg      <= 8'd0;
            prev_full_reg <= 1'b1;
            count_reg     <= '0;
            start_reg     <= 1'b1;
            finished_reg  <= 1'b0;
        end else if (accept) begin
            left_reg      <= left_next;
            prev_full_reg <= prev_full_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            finished_reg  <= finished_next;
        end
    end

    // A buffer that has just started has written nothing and finished nothing.
    a_start_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (count_reg == '0 && !finished_reg && left_reg == 8'd0))
        else $error("front: buffer start with stale state");

endmodule

FILE: sv/cfd_queue.sv
// Short request queue that decouples the front end from the result stage.
module cfd_queue
    import cfd_pkg::*;
#(
    parameter int DEPTH = CFD_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  cfd_req_t push_req,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output cfd_req_t head_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cfd_req_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_pop;

    assign full       = (fill_reg == CNT_FULL);
    assign head_valid = (fill_reg != '0);
    assign head_req   = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Fill level follows pushes and pops.
    always_comb begin
        fill_next = fill_reg;
        if (push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (!push && do_pop) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    // The front end must never write into a full queue.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue: push while full");

endmodule

FILE: sv/cfd_back.sv
// Back end: turns queued requests into data results and end records.
module cfd_back
    import cfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  cfd_req_t    q_req,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [2:0]  m_out_status,
    output logic [15:0] m_out_count,
    output logic        m_out_last
);

    logic        m_valid_reg, m_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] count_reg, count_next;
    logic        last_reg, last_next;
    logic        phase_reg, phase_next;
    logic        load;

    assign load = !m_valid_reg || m_ready;

    // Pick the next result beat from the head request.
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        phase_next   = phase_reg;
        q_pop        = 1'b0;
        if (load) begin
            m_valid_next = q_valid;
            if (q_valid) begin
                count_next = q_req.count;
                if (q_req.has_data && !phase_reg) begin
                    kind_next   = CFD_KIND_DATA;
                    byte_next   = q_req.data_byte;
                    status_next = CFD_ST_OK;
                    last_next   = !q_req.has_rec;
                    phase_next  = q_req.has_rec;
                    q_pop       = !q_req.has_rec;
                end else begin
                    kind_next   = CFD_KIND_REC;
                    byte_next   = CFD_DELIM;
                    status_next = q_req.status;
                    last_next   = 1'b1;
                    phase_next  = 1'b0;
                    q_pop       = 1'b1;
                end
            end
        end
    end

    // Output register and beat phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_out_byte   = byte_reg;
    assign m_out_status = status_reg;
    assign m_out_count  = count_reg;
    assign m_out_last   = last_reg;

    // Between the two beats of one request its record is still at the head.
    a_phase_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (q_valid && q_req.has_data && q_req.has_rec))
        else $error("back: second beat lost its request");

    // A record always closes the results of its input byte.
    a_rec_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == CFD_KIND_REC) |-> last_reg)
        else $error("back: record not marked last");

    // A data beat followed by its record is never marked last.
    a_data_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && phase_reg) |-> (!last_reg && kind_reg == CFD_KIND_DATA))
        else $error("back: first beat of a pair marked last");

endmodule

FILE: sv/cobs_frame_decoder.sv
// COBS frame decoder top level: capacity register, front end, request queue and result stage.
// The decoder accepts one encoded byte per clock cycle while the request queue is not full. Each
// byte is classified in the front end in the cycle it is accepted and the resulting request is
// queued; the result stage drives at most one result per cycle from its output register. A byte
// that yields both a data byte and an end record occupies the output for a data beat and a record
// beat; the request queue (four entries by default) absorbs these and any output stalls while
// input continues. Sustained throughput is one byte per cycle while the queue is not full,
// bounded by the single result per cycle of the output port. The capacity register is written
// through cfg_wr_en and cfg_wr_data and should only change while the decoder is idle.
module cobs_frame_decoder
    import cfd_pkg::*;
#(
    parameter int COUNT_WIDTH = CFD_COUNT_WIDTH,
    parameter int QUEUE_DEPTH = CFD_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [2:0]  m_out_status,
    output logic [15:0] m_out_count,
    output logic        m_out_last
);

    logic [15:0] capacity_reg;
    logic        q_full, q_push, q_pop, q_valid;
    cfd_req_t    push_req, head_req;

    // Output capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CFD_CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    cfd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .capacity  (capacity_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_req     (push_req)
    );

    cfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_req   (push_req),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_req   (head_req)
    );

    cfd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_req        (head_req),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_kind   (m_out_kind),
        .m_out_byte   (m_out_byte),
        .m_out_status (m_out_status),
        .m_out_count  (m_out_count),
        .m_out_last   (m_out_last)
    );

endmodule
